[rtl/vmtf_pkg.sv]
package vmtf_pkg;

  localparam int unsigned MAX_VARS_DEF   = 4096;
  localparam int unsigned STAMP_BITS_DEF = 32;

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_BUMP     = 3'd1,
    MODE_DECIDE   = 3'd2,
    MODE_SET_ASG  = 3'd3,
    MODE_SET_ELIM = 3'd4,
    MODE_REBUILD  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    ST_ADD_V,
    ST_ADD_TAIL,
    ST_ADD_HINT,
    ST_BMP_V,
    ST_BMP_P,
    ST_BMP_N,
    ST_BMP_V2,
    ST_BMP_TAIL,
    ST_DEC,
    ST_SET_ASG,
    ST_SET_ELIM,
    ST_RB,
    ST_RB_LINK
  } step_e;

endpackage

[rtl/vmtf_ram.sv]
module vmtf_ram import vmtf_pkg::*; #(
  parameter int unsigned DEPTH = MAX_VARS_DEF,
  parameter int unsigned WIDTH = 2 * ($clog2(MAX_VARS_DEF + 1)) + STAMP_BITS_DEF + 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/vmtf_decision_queue_core.sv]
// Move-to-front decision queue; one item at a time, one RAM access pair per step.
// Ignored ops go straight to the output state; flag sets, adds and bumps run read-modify
// steps, a decision walks back one entry per step, and a rebuild visits every entry.
// The next beat is taken in the cycle the result appears, and a stalled result holds the
// block in its output state.
// After reset a clearing pass first writes all MAX_VARS entries.
module vmtf_decision_queue_core import vmtf_pkg::*; #(
  parameter int unsigned MAX_VARS   = MAX_VARS_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] var_index_i,
  input  logic        flag_value_i,
  input  logic [12:0] var_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] result_var_o,
  output logic        result_found_o
);

  localparam int unsigned IW = $clog2(MAX_VARS);
  localparam int unsigned LW = $clog2(MAX_VARS + 1);
  localparam int unsigned SB = STAMP_BITS;
  localparam int unsigned WW = 2 * LW + SB + 2;
  localparam logic [LW-1:0] NONE = LW'(MAX_VARS);

  function automatic logic is_idx(input logic [LW-1:0] x);
    is_idx = (x < NONE);
  endfunction

  // entry word: {elim, asg, stamp, next, prev}
  function automatic logic [WW-1:0] pack_word(input logic el, input logic as,
                                              input logic [SB-1:0] st,
                                              input logic [LW-1:0] nx,
                                              input logic [LW-1:0] pv);
    pack_word = {el, as, st, nx, pv};
  endfunction

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic [IW-1:0] addr_q, addr_d;
  logic [LW-1:0] v_q, v_d, p_q, p_d, n_q, n_d, i_q, i_d, nv_q, nv_d, steps_q, steps_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, hint_q, hint_d, tsize_q, tsize_d;
  logic [SB-1:0] ctr_q, ctr_d, fresh;
  logic          asg_q, asg_d, fl_q, fl_d, dme_q;
  logic [11:0]   rvar_q, rvar_d, ovar_q, ovar_d;
  logic          rfound_q, rfound_d, ofound_q, ofound_d, ovalid_q, ovalid_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [WW-1:0] wdata, rdata;

  logic [LW-1:0] r_prev, r_next;
  logic [SB-1:0] r_stamp;
  logic          r_asg, r_elim, v_ok;

  assign r_prev  = rdata[LW-1:0];
  assign r_next  = rdata[2*LW-1:LW];
  assign r_stamp = rdata[2*LW+SB-1:2*LW];
  assign r_asg   = rdata[2*LW+SB];
  assign r_elim  = rdata[2*LW+SB+1];

  assign v_ok  = 32'(var_index_i) < 32'(MAX_VARS);
  assign fresh = (ctr_q == {SB{1'b1}}) ? ctr_q : ctr_q + SB'(1);

  vmtf_ram #(
    .DEPTH (MAX_VARS),
    .WIDTH (WW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      step_q   <= ST_RB;
      i_q      <= '0;
      head_q   <= NONE;
      tail_q   <= NONE;
      hint_q   <= NONE;
      ctr_q    <= '0;
      tsize_q  <= '0;
      dme_q    <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      i_q      <= i_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      hint_q   <= hint_d;
      ctr_q    <= ctr_d;
      tsize_q  <= tsize_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        dme_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    v_q      <= v_d;
    p_q      <= p_d;
    n_q      <= n_d;
    nv_q     <= nv_d;
    steps_q  <= steps_d;
    asg_q    <= asg_d;
    fl_q     <= fl_d;
    rvar_q   <= rvar_d;
    rfound_q <= rfound_d;
    ovar_q   <= ovar_d;
    ofound_q <= ofound_d;
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    addr_d   = addr_q;
    v_d      = v_q;
    p_d      = p_q;
    n_d      = n_q;
    i_d      = i_q;
    nv_d     = nv_q;
    steps_d  = steps_q;
    asg_d    = asg_q;
    fl_d     = fl_q;
    head_d   = head_q;
    tail_d   = tail_q;
    hint_d   = hint_q;
    ctr_d    = ctr_q;
    tsize_d  = tsize_q;
    rvar_d   = rvar_q;
    rfound_d = rfound_q;
    ovar_d   = ovar_q;
    ofound_d = ofound_q;
    ovalid_d = ovalid_q;
    we       = 1'b0;
    waddr    = addr_q;
    wdata    = rdata;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = IW'(i_q);
        wdata = pack_word(1'b0, 1'b0, '0, NONE, NONE);
        i_d   = i_q + LW'(1);
        if (i_q == NONE - LW'(1)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          rvar_d   = '0;
          rfound_d = 1'b0;
          v_d      = LW'(var_index_i);
          addr_d   = IW'(var_index_i);
          fl_d     = flag_value_i;
          state_d  = S_OUT;
          case (mode_e'(mode_i))
            MODE_ADD: begin
              if (v_ok) begin
                step_d  = ST_ADD_V;
                state_d = S_READ;
              end
            end
            MODE_BUMP: begin
              if (v_ok && LW'(var_index_i) < tsize_q) begin
                step_d  = ST_BMP_V;
                state_d = S_READ;
              end
            end
            MODE_DECIDE: begin
              steps_d = '0;
              if (is_idx(hint_q)) begin
                addr_d  = IW'(hint_q);
                step_d  = ST_DEC;
                state_d = S_READ;
              end
            end
            MODE_SET_ASG: begin
              if (v_ok) begin
                step_d  = ST_SET_ASG;
                state_d = S_READ;
              end
            end
            MODE_SET_ELIM: begin
              if (v_ok) begin
                step_d  = ST_SET_ELIM;
                state_d = S_READ;
              end
            end
            MODE_REBUILD: begin
              if (dme_q && tsize_q != '0) begin
                nv_d    = (32'(var_count_i) > 32'(MAX_VARS)) ? NONE : LW'(var_count_i);
                tsize_d = nv_d;
                head_d  = NONE;
                tail_d  = NONE;
                hint_d  = NONE;
                ctr_d   = '0;
                i_d     = '0;
                addr_d  = '0;
                step_d  = ST_RB;
                state_d = S_READ;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_READ: state_d = S_MOD;

      S_MOD: begin
        state_d = S_OUT;
        case (step_q)
          ST_ADD_V: begin
            if (head_q != v_q && !is_idx(r_prev)) begin
              if (tsize_q < v_q + LW'(1)) begin
                tsize_d = v_q + LW'(1);
              end
              we    = 1'b1;
              wdata = pack_word(r_elim, r_asg, fresh, NONE, tail_q);
              ctr_d = fresh;
              asg_d = r_asg;
              if (is_idx(tail_q)) begin
                addr_d  = IW'(tail_q);
                step_d  = ST_ADD_TAIL;
                state_d = S_READ;
              end else begin
                head_d = v_q;
                tail_d = v_q;
                if (!r_asg) begin
                  if (!is_idx(hint_q)) begin
                    hint_d = v_q;
                  end else begin
                    addr_d  = IW'(hint_q);
                    step_d  = ST_ADD_HINT;
                    state_d = S_READ;
                  end
                end
              end
            end
          end
          ST_ADD_TAIL: begin
            we     = 1'b1;
            wdata  = pack_word(r_elim, r_asg, r_stamp, v_q, r_prev);
            tail_d = v_q;
            if (!asg_q) begin
              if (!is_idx(hint_q)) begin
                hint_d = v_q;
              end else begin
                addr_d  = IW'(hint_q);
                step_d  = ST_ADD_HINT;
                state_d = S_READ;
              end
            end
          end
          ST_ADD_HINT: begin
            // ctr_q holds the stamp just given to v
            if (ctr_q > r_stamp) begin
              hint_d = v_q;
            end
          end
          ST_BMP_V: begin
            if (is_idx(r_next)) begin
              p_d     = r_prev;
              n_d     = r_next;
              asg_d   = r_asg;
              state_d = S_READ;
              if (is_idx(r_prev)) begin
                addr_d = IW'(r_prev);
                step_d = ST_BMP_P;
              end else begin
                head_d = r_next;
                addr_d = IW'(r_next);
                step_d = ST_BMP_N;
              end
            end
          end
          ST_BMP_P: begin
            we      = 1'b1;
            wdata   = pack_word(r_elim, r_asg, r_stamp, n_q, r_prev);
            addr_d  = IW'(n_q);
            step_d  = ST_BMP_N;
            state_d = S_READ;
          end
          ST_BMP_N: begin
            we      = 1'b1;
            wdata   = pack_word(r_elim, r_asg, r_stamp, r_next, p_q);
            addr_d  = IW'(v_q);
            step_d  = ST_BMP_V2;
            state_d = S_READ;
          end
          ST_BMP_V2: begin
            // tail is valid and not v: v still had a successor
            we      = 1'b1;
            wdata   = pack_word(r_elim, r_asg, fresh, NONE, tail_q);
            ctr_d   = fresh;
            addr_d  = IW'(tail_q);
            step_d  = ST_BMP_TAIL;
            state_d = S_READ;
          end
          ST_BMP_TAIL: begin
            we     = 1'b1;
            wdata  = pack_word(r_elim, r_asg, r_stamp, v_q, r_prev);
            tail_d = v_q;
            if (!asg_q) begin
              hint_d = v_q;
            end
          end
          ST_DEC: begin
            if (!r_asg && !r_elim) begin
              hint_d   = LW'(addr_q);
              rvar_d   = 12'(addr_q);
              rfound_d = 1'b1;
            end else if (steps_q < NONE) begin
              steps_d = steps_q + LW'(1);
              if (is_idx(r_prev)) begin
                addr_d  = IW'(r_prev);
                step_d  = ST_DEC;
                state_d = S_READ;
              end
            end
          end
          ST_SET_ASG: begin
            we    = 1'b1;
            wdata = pack_word(r_elim, fl_q, r_stamp, r_next, r_prev);
          end
          ST_SET_ELIM: begin
            we    = 1'b1;
            wdata = pack_word(fl_q, r_asg, r_stamp, r_next, r_prev);
          end
          ST_RB, ST_RB_LINK: begin
            we = 1'b1;
            if (step_q == ST_RB_LINK) begin
              wdata = pack_word(r_elim, r_asg, r_stamp, i_q, r_prev);
            end else if (i_q < nv_q && !r_elim) begin
              wdata = pack_word(r_elim, r_asg, fresh, NONE, tail_q);
              ctr_d = fresh;
              if (!r_asg) begin
                hint_d = i_q;
              end
              tail_d = i_q;
              if (!is_idx(tail_q)) begin
                head_d = i_q;
              end
            end else begin
              wdata = pack_word(r_elim, r_asg, '0, NONE, NONE);
            end

            if (step_q == ST_RB && i_q < nv_q && !r_elim && is_idx(tail_q)) begin
              // link old tail to this entry before moving on
              addr_d  = IW'(tail_q);
              step_d  = ST_RB_LINK;
              state_d = S_READ;
            end else if (i_q != NONE - LW'(1)) begin
              i_d     = i_q + LW'(1);
              addr_d  = IW'(i_q + LW'(1));
              step_d  = ST_RB;
              state_d = S_READ;
            end
          end
          default: state_d = S_OUT;
        endcase
      end

      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          ovar_d   = rvar_q;
          ofound_d = rfound_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign result_var_o   = ovar_q;
  assign result_found_o = ofound_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted beat did not make the block busy");

  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q != $past(ctr_q) |-> ctr_q == $past(ctr_q) + SB'(1) || ctr_q == '0)
    else $error("stamp counter moved other than by one or a restart");

  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> is_idx(head_q) == is_idx(tail_q))
    else $error("queue head and tail disagree on emptiness");

  a_zero_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_found_o |-> result_var_o == '0)
    else $error("result variable nonzero without a find");

endmodule
